>>> rtl/core/legr_pkg.sv
// ----------------------------------------------------------------------------
// legr_pkg
// shared types, codes and constants of the list engine with group reverse
// ----------------------------------------------------------------------------
package legr_pkg;

    localparam int unsigned CAPACITY_DEF = 64;
    localparam int unsigned CNT_W        = 7;
    localparam int unsigned DATA_W       = 32;

    typedef enum logic [2:0] {
        CMD_APPEND  = 3'd0,
        CMD_DELETE  = 3'd1,
        CMD_INSERT  = 3'd2,
        CMD_MULT    = 3'd3,
        CMD_GREV    = 3'd4,
        CMD_SHOW    = 3'd5,
        CMD_RSVD6   = 3'd6,
        CMD_RSVD7   = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_REJECT = 2'd1,
        ST_ELEM   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // memory port request from the sequencer
    typedef struct packed {
        logic              rd_en;
        logic [CNT_W-1:0]  rd_addr;
        logic              wr_en;
        logic [CNT_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
    } t_mem_req;

endpackage

>>> rtl/core/legr_mem.sv
// ----------------------------------------------------------------------------
// legr_mem
// element store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module legr_mem
    import legr_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic              i_clk,
    input  t_mem_req          i_req,
    output logic [DATA_W-1:0] o_rd_data
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [DATA_W-1:0] r_mem [CAPACITY];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/legr_seq.sv
// ----------------------------------------------------------------------------
// legr_seq
// command sequencer: decodes one command and walks the element store
// ----------------------------------------------------------------------------
module legr_seq
    import legr_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_cmd,
    input  logic [CNT_W-1:0]  i_position,
    input  logic [CNT_W-1:0]  i_group_size,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_factor,
    output t_mem_req          o_mem,
    input  logic [DATA_W-1:0] i_rd_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic [DATA_W-1:0] o_element,
    output logic              o_last,
    output logic [CNT_W-1:0]  o_length
);

    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_SHIFT_RD, S_SHIFT_WR, S_MUL_RD, S_MUL_WR,
        S_REV_RD_A, S_REV_RD_B, S_REV_WR_A, S_REV_WR_B, S_REV_NEXT,
        S_SHOW_RD, S_SHOW_OUT, S_RESP
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_end;
    logic [CNT_W-1:0]  r_lo;
    logic [CNT_W-1:0]  r_hi;
    logic [CNT_W-1:0]  r_k;
    logic              r_dir_up;
    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] r_tmp;
    logic              r_valid;
    logic [1:0]        r_status;
    logic [DATA_W-1:0] r_element;
    logic              r_last;
    logic [CNT_W-1:0]  r_length;
    logic              r_mul_ld;

    logic [DATA_W-1:0] w_prod;
    logic [CNT_W-1:0]  w_ipos;
    logic [CNT_W:0]    w_gend;
    logic [CNT_W-1:0]  w_gend_c;
    logic              w_out_free;

    assign w_prod     = i_rd_data * r_val;
    assign w_ipos     = (i_position == '0) ? ONE : i_position;
    assign w_out_free = !r_valid || i_ready;
    assign o_ready    = (r_state == S_IDLE) && w_out_free;

    // end of the group that opens at r_lo, clipped to the list
    assign w_gend   = {1'b0, r_lo} + {1'b0, r_k} - (CNT_W+1)'(1);
    assign w_gend_c = (w_gend >= {1'b0, r_count}) ? (r_count - ONE) : w_gend[CNT_W-1:0];

    always_comb begin
        o_mem = '0;
        unique case (r_state)
            S_SHIFT_RD: begin
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = r_dir_up ? (r_idx + ONE) : (r_idx - ONE);
            end
            S_SHIFT_WR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_idx;
                o_mem.wr_data = i_rd_data;
            end
            S_MUL_RD: begin
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = r_idx;
            end
            S_MUL_WR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_idx;
                o_mem.wr_data = r_mul_ld ? w_prod : r_tmp;
            end
            S_REV_RD_A: begin
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = r_lo;
            end
            S_REV_RD_B: begin
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = r_hi;
            end
            S_REV_WR_A: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_lo;
                o_mem.wr_data = i_rd_data;
            end
            S_REV_WR_B: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_hi;
                o_mem.wr_data = r_tmp;
            end
            S_SHOW_RD: begin
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = r_idx;
            end
            default: begin
                if (r_state == S_IDLE && o_ready && i_valid && i_cmd == CMD_APPEND
                        && r_count < CAP) begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = r_count;
                    o_mem.wr_data = i_value;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_ready && i_valid) begin
                        r_status <= ST_REJECT;
                        r_element <= '0;
                        r_last   <= 1'b1;
                        r_length <= r_count;
                        r_val    <= i_factor;
                        r_k      <= i_group_size;
                        r_state  <= S_RESP;
                        unique case (t_cmd'(i_cmd))
                            CMD_APPEND: begin
                                if (r_count < CAP) begin
                                    r_count  <= r_count + ONE;
                                    r_length <= r_count + ONE;
                                    r_status <= ST_DONE;
                                end
                            end
                            CMD_DELETE: begin
                                if (i_position != '0 && i_position <= r_count) begin
                                    r_count  <= r_count - ONE;
                                    r_length <= r_count - ONE;
                                    r_status <= ST_DONE;
                                    r_idx    <= i_position - ONE;
                                    r_end    <= r_count - ONE;
                                    r_dir_up <= 1'b1;
                                    if (i_position != r_count) r_state <= S_SHIFT_RD;
                                end
                            end
                            CMD_INSERT: begin
                                if (w_ipos <= r_count && r_count < CAP) begin
                                    r_count  <= r_count + ONE;
                                    r_length <= r_count + ONE;
                                    r_status <= ST_DONE;
                                    r_idx    <= r_count;
                                    r_end    <= w_ipos;
                                    r_dir_up <= 1'b0;
                                    r_tmp    <= i_value;
                                    r_state  <= (r_count == w_ipos) ? S_MUL_WR : S_SHIFT_RD;
                                    if (r_count == w_ipos) r_idx <= w_ipos;
                                end
                            end
                            CMD_MULT: begin
                                if (i_position != '0 && i_position <= r_count) begin
                                    r_status <= ST_DONE;
                                    r_idx    <= r_count - i_position;
                                    r_state  <= S_MUL_RD;
                                end
                            end
                            CMD_GREV: begin
                                if (i_group_size <= ONE) begin
                                    r_status <= ST_DONE;
                                end else if (r_count != '0) begin
                                    r_status <= ST_DONE;
                                    r_lo     <= '0;
                                    r_state  <= S_REV_NEXT;
                                end
                            end
                            CMD_SHOW: begin
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_idx   <= '0;
                                    r_state <= S_SHOW_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SHIFT_RD: r_state <= S_SHIFT_WR;
                S_SHIFT_WR: begin
                    if (r_dir_up) begin
                        r_idx <= r_idx + ONE;
                        r_state <= (r_idx + ONE == r_end) ? S_RESP : S_SHIFT_RD;
                    end else begin
                        r_idx <= r_idx - ONE;
                        if (r_idx - ONE == r_end) begin
                            r_state <= S_MUL_WR;
                        end else begin
                            r_state <= S_SHIFT_RD;
                        end
                    end
                end
                S_MUL_RD: r_state <= S_MUL_WR;
                S_MUL_WR: begin
                    r_state <= S_RESP;
                end
                S_REV_NEXT: begin
                    if (r_lo >= r_count) begin
                        r_state <= S_RESP;
                    end else begin
                        r_hi   <= w_gend_c;
                        r_end  <= w_gend[CNT_W-1:0] + ONE;
                        r_state <= (w_gend_c > r_lo) ? S_REV_RD_A : S_REV_NEXT;
                        if (!(w_gend_c > r_lo)) r_lo <= w_gend[CNT_W-1:0] + ONE;
                        if (w_gend >= {1'b0, r_count}) begin
                            if (!(w_gend_c > r_lo)) r_lo <= r_count;
                        end
                    end
                end
                S_REV_RD_A: r_state <= S_REV_RD_B;
                S_REV_RD_B: begin
                    r_tmp   <= i_rd_data;
                    r_state <= S_REV_WR_A;
                end
                S_REV_WR_A: r_state <= S_REV_WR_B;
                S_REV_WR_B: begin
                    if (r_lo + ONE < r_hi - ONE) begin
                        r_lo    <= r_lo + ONE;
                        r_hi    <= r_hi - ONE;
                        r_state <= S_REV_RD_A;
                    end else begin
                        r_lo    <= (r_end > r_count) ? r_count : r_end;
                        r_state <= S_REV_NEXT;
                    end
                end
                S_SHOW_RD: begin
                    if (w_out_free) r_state <= S_SHOW_OUT;
                end
                S_SHOW_OUT: begin
                    r_valid   <= 1'b1;
                    r_status  <= ST_ELEM;
                    r_element <= i_rd_data;
                    r_length  <= r_count;
                    r_last    <= (r_idx + ONE == r_count);
                    r_idx     <= r_idx + ONE;
                    r_state   <= (r_idx + ONE == r_count) ? S_IDLE : S_SHOW_RD;
                end
                S_RESP: begin
                    if (w_out_free) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // multiply writes the product of the read word, insert the held value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mul_ld <= 1'b0;
        else r_mul_ld <= (r_state == S_MUL_RD);
    end

    assign o_valid   = r_valid;
    assign o_status  = r_status;
    assign o_element = r_element;
    assign o_last    = r_last;
    assign o_length  = r_length;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP) else $error("count above capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.wr_en |-> o_mem.wr_addr < CAP) else $error("write beyond capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> r_valid) else $error("beat dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");

endmodule

>>> rtl/core/list_engine_group_reverse_unit.sv
// ----------------------------------------------------------------------------
// list_engine_group_reverse_unit
// ordered list of signed words driven by one command per beat
// ----------------------------------------------------------------------------
// usage:
//   slave stream carries one command per beat; master stream returns one
//   status beat per command, or one beat per element for show of a non-empty
//   list, the final beat of each command marked by tlast.
//   append, reject and reverse with group size of one or less give only a
//   status beat. delete and insert move each shifted element by one read
//   and one write, and insert then writes the new value; group reverse
//   swaps each pair by two reads and two writes; show reads each element
//   before its beat. all of this goes through the single read and single
//   write port of the element store, whose read data is registered.
//   one command is worked at a time; a new one is taken once the previous
//   command's last beat leaves the output register, in that same cycle at
//   the earliest.
//   reset empties the list; stored words need no clearing.
//   a stalled receiver holds the output beat and the sequencer waits.
// ----------------------------------------------------------------------------
module list_engine_group_reverse_unit
    import legr_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[2:0], position[9:3], group_size[16:10], value[48:17], factor[80:49]
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], element[33:2], length[40:34]
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    t_mem_req          w_mem;
    logic [DATA_W-1:0] w_rd_data;
    logic [1:0]        w_status;
    logic [DATA_W-1:0] w_element;
    logic [CNT_W-1:0]  w_length;

    legr_mem #(.CAPACITY(CAPACITY)) u_mem (
        .i_clk     (i_clk),
        .i_req     (w_mem),
        .o_rd_data (w_rd_data)
    );

    legr_seq #(.CAPACITY(CAPACITY)) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_cmd        (s_axis_tdata[2:0]),
        .i_position   (s_axis_tdata[9:3]),
        .i_group_size (s_axis_tdata[16:10]),
        .i_value      (s_axis_tdata[48:17]),
        .i_factor     (s_axis_tdata[80:49]),
        .o_mem        (w_mem),
        .i_rd_data    (w_rd_data),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_status     (w_status),
        .o_element    (w_element),
        .o_last       (m_axis_tlast),
        .o_length     (w_length)
    );

    assign m_axis_tdata = {7'd0, w_length, w_element, w_status};

endmodule
